@@ design/frk_pkg.sv @@
// frk_pkg: widths, types, register codes and the key-select function shared
// by all float_key_radix_sorter files. No dependencies.
package frk_pkg;

  localparam int MAX_ITEMS = 64;                       // vectors held per set, 1..64
  localparam int AW        = $clog2(MAX_ITEMS);        // store address width
  localparam int CW        = $clog2(MAX_ITEMS + 1);    // count width, holds MAX_ITEMS
  localparam int COMP_W    = 32;
  localparam int VEC_W     = 4 * COMP_W;
  localparam int PASS_W    = 5;
  localparam logic [PASS_W-1:0] LAST_PASS = 5'd31;

  localparam int QDEPTH    = 2;                        // front/back queue, power of two
  localparam int QAW       = $clog2(QDEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int AXIS_W     = 2;
  localparam int CCNT_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SORT_AXIS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT = 1'd1;

  // axis codes
  localparam logic [AXIS_W-1:0] AX_X = 2'd0;
  localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AX_Z = 2'd2;
  localparam logic [AXIS_W-1:0] AX_W = 2'd3;

  localparam logic [CCNT_W-1:0] COMP_THREE = 3'd3;
  localparam logic [CCNT_W-1:0] COMP_RESET = 3'd4;

  typedef logic [VEC_W-1:0] vec_t;

  typedef struct packed {
    vec_t vec;
    logic keep;   // vector is stored (set not yet full)
    logic fin;    // last word of the set, starts the sort
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic              three;
  } cfg_t;

  // key = raw bits of the chosen component; w reads as zero with three components
  function automatic logic [COMP_W-1:0] key_of(vec_t v, logic [AXIS_W-1:0] axis,
                                              logic three);
    logic [COMP_W-1:0] k;
    unique case (axis)
      AX_X:    k = v[COMP_W-1:0];
      AX_Y:    k = v[2*COMP_W-1:COMP_W];
      AX_Z:    k = v[3*COMP_W-1:2*COMP_W];
      AX_W:    k = three ? '0 : v[4*COMP_W-1:3*COMP_W];
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ design/frk_ram.sv @@
// frk_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module frk_ram #(
  parameter int W     = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/frk_front.sv @@
// frk_front: accepts input words, marks each as kept or dropped (set full)
// and as end of set, and pushes it to the queue. Depends on frk_pkg.
module frk_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  frk_pkg::vec_t                in_tdata,
  input  logic                         in_tlast,
  input  frk_pkg::q_stat_t             q_stat,
  output logic                         push,
  output frk_pkg::q_entry_t            entry
);

  logic [frk_pkg::CW-1:0] fr_cnt_r, fr_cnt_nxt;
  logic                   keep;

  assign in_tready  = !q_stat.full;
  assign push       = in_tvalid && in_tready;
  assign keep       = fr_cnt_r < frk_pkg::CW'(frk_pkg::MAX_ITEMS);
  assign entry.vec  = in_tdata;
  assign entry.keep = keep;
  assign entry.fin  = in_tlast;

  always_comb begin
    fr_cnt_nxt = fr_cnt_r;
    if (push) begin
      if (in_tlast) begin
        fr_cnt_nxt = '0;
      end else if (keep) begin
        fr_cnt_nxt = fr_cnt_r + frk_pkg::CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_cnt_r <= '0;
    end else begin
      fr_cnt_r <= fr_cnt_nxt;
    end
  end

endmodule

@@ design/frk_queue.sv @@
// frk_queue: short FIFO of classified words between front and back.
// Depends on frk_pkg.
module frk_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  frk_pkg::q_entry_t  wr_entry,
  input  logic               pop,
  output frk_pkg::q_entry_t  rd_entry,
  output frk_pkg::q_stat_t   stat
);

  frk_pkg::q_entry_t mem [frk_pkg::QDEPTH];

  logic [frk_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [frk_pkg::QAW:0]   cnt_r, cnt_nxt;

  assign rd_entry   = mem[rd_ptr_r];
  assign stat.full  = cnt_r == (frk_pkg::QAW+1)'(frk_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (frk_pkg::QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (frk_pkg::QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + frk_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + frk_pkg::QAW'(1);
      end
    end
  end

endmodule

@@ design/frk_back.sv @@
// frk_back: loads queued vectors into store A, runs 32 stable one-bit
// partition passes ping-ponging between stores A and B, then emits the set
// with the negative tail reversed in front. Depends on frk_pkg, frk_ram.
module frk_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  frk_pkg::q_entry_t    q_entry,
  input  frk_pkg::q_stat_t     q_stat,
  output logic                 pop,
  input  frk_pkg::cfg_t        cfg,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output frk_pkg::vec_t        out_tdata,
  output logic                 out_tlast
);

  typedef enum logic [1:0] {S_LOAD, S_COUNT, S_PASS, S_OUT} state_t;

  localparam int CW = frk_pkg::CW;
  localparam int AW = frk_pkg::AW;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 ld_cnt_r, ld_cnt_nxt;
  logic [CW-1:0]                 n_r, n_nxt;
  logic [CW-1:0]                 rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]                 lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]                 c_r, c_nxt, acc_r, acc_nxt;
  logic [frk_pkg::PASS_W-1:0]    pass_r, pass_nxt;
  logic [frk_pkg::AXIS_W-1:0]    axis_r, axis_nxt;
  logic                          three_r, three_nxt;
  logic                          pend_r, pend_nxt;
  logic                          pend_last_r, pend_last_nxt;
  logic                          out_vld_r, out_vld_nxt;
  frk_pkg::vec_t                 out_data_r, out_data_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          a_we, b_we;
  logic [AW-1:0]                 a_waddr, b_waddr, rd_addr;
  frk_pkg::vec_t                 a_wdata, a_rdata, b_rdata, rd_data;
  logic [frk_pkg::COMP_W-1:0]    key;
  logic [frk_pkg::PASS_W-1:0]    cnt_bit;
  logic                          part_bit, bit_clr, all_issued, issue, done;
  logic [CW-1:0]                 neg, out_idx;

  frk_ram #(.W(frk_pkg::VEC_W), .DEPTH(frk_pkg::MAX_ITEMS)) u_ram_a (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(rd_addr), .rdata(a_rdata)
  );

  frk_ram #(.W(frk_pkg::VEC_W), .DEPTH(frk_pkg::MAX_ITEMS)) u_ram_b (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(rd_data), .raddr(rd_addr), .rdata(b_rdata)
  );

  // odd passes read B; counting, even passes and output read A
  assign rd_data    = (state_r == S_PASS && pass_r[0]) ? b_rdata : a_rdata;
  assign key        = frk_pkg::key_of(rd_data, axis_r, three_r);
  assign cnt_bit    = (state_r == S_COUNT) ? pass_r : pass_r + frk_pkg::PASS_W'(1);
  assign part_bit   = key[pass_r];
  assign bit_clr    = !key[cnt_bit];
  assign all_issued = rd_idx_r == n_r;
  assign done       = all_issued && !pend_r;

  // output order: negatives (top of the sorted store) reversed, then the rest
  assign neg     = n_r - c_r;
  assign out_idx = (rd_idx_r < neg) ? (n_r - CW'(1) - rd_idx_r) : (rd_idx_r - neg);

  assign pop = (state_r == S_LOAD) && !q_stat.empty;

  always_comb begin
    issue   = 1'b0;
    rd_addr = rd_idx_r[AW-1:0];
    unique case (state_r)
      S_COUNT, S_PASS: issue = !all_issued;
      S_OUT: begin
        issue   = !all_issued && !pend_r && (!out_vld_r || out_tready);
        rd_addr = out_idx[AW-1:0];
      end
      default: issue = 1'b0;
    endcase
  end

  // store writes: A takes loads and odd-pass results, B even-pass results
  always_comb begin
    a_we    = 1'b0;
    a_waddr = part_bit ? hi_r[AW-1:0] : lo_r[AW-1:0];
    a_wdata = rd_data;
    b_we    = 1'b0;
    b_waddr = part_bit ? hi_r[AW-1:0] : lo_r[AW-1:0];
    if (state_r == S_LOAD) begin
      a_we    = pop && q_entry.keep;
      a_waddr = ld_cnt_r[AW-1:0];
      a_wdata = q_entry.vec;
    end else if (state_r == S_PASS && pend_r) begin
      a_we = pass_r[0];
      b_we = !pass_r[0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ld_cnt_nxt    = ld_cnt_r;
    n_nxt         = n_r;
    rd_idx_nxt    = rd_idx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    c_nxt         = c_r;
    acc_nxt       = acc_r;
    pass_nxt      = pass_r;
    axis_nxt      = axis_r;
    three_nxt     = three_r;
    pend_nxt      = issue;
    pend_last_nxt = pend_last_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (issue) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
    end

    unique case (state_r)
      S_LOAD: begin
        if (pop) begin
          ld_cnt_nxt = ld_cnt_r + CW'(q_entry.keep);
          if (q_entry.fin) begin
            n_nxt      = ld_cnt_r + CW'(q_entry.keep);
            ld_cnt_nxt = '0;
            axis_nxt   = cfg.axis;
            three_nxt  = cfg.three;
            rd_idx_nxt = '0;
            pass_nxt   = '0;
            acc_nxt    = '0;
            state_nxt  = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        if (pend_r) begin
          acc_nxt = acc_r + CW'(bit_clr);
        end
        if (done) begin
          c_nxt      = acc_r;
          hi_nxt     = acc_r;
          lo_nxt     = '0;
          acc_nxt    = '0;
          rd_idx_nxt = '0;
          state_nxt  = S_PASS;
        end
      end
      S_PASS: begin
        if (pend_r) begin
          // count the next pass's clear keys on the fly
          acc_nxt = acc_r + CW'(bit_clr);
          if (part_bit) begin
            hi_nxt = hi_r + CW'(1);
          end else begin
            lo_nxt = lo_r + CW'(1);
          end
        end
        if (done) begin
          rd_idx_nxt = '0;
          if (pass_r == frk_pkg::LAST_PASS) begin
            state_nxt = S_OUT;
          end else begin
            pass_nxt = pass_r + frk_pkg::PASS_W'(1);
            c_nxt    = acc_r;
            hi_nxt   = acc_r;
            lo_nxt   = '0;
            acc_nxt  = '0;
          end
        end
      end
      S_OUT: begin
        if (issue) begin
          pend_last_nxt = rd_idx_r == n_r - CW'(1);
        end
        if (pend_r) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = rd_data;
          if (three_r) begin
            out_data_nxt[frk_pkg::VEC_W-1:3*frk_pkg::COMP_W] = '0;
          end
          out_last_nxt = pend_last_r;
        end
        if (done) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      ld_cnt_r  <= '0;
      n_r       <= '0;
      rd_idx_r  <= '0;
      lo_r      <= '0;
      hi_r      <= '0;
      c_r       <= '0;
      acc_r     <= '0;
      pass_r    <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ld_cnt_r  <= ld_cnt_nxt;
      n_r       <= n_nxt;
      rd_idx_r  <= rd_idx_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      c_r       <= c_nxt;
      acc_r     <= acc_nxt;
      pass_r    <= pass_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
    axis_r      <= axis_nxt;
    three_r     <= three_nxt;
    pend_last_r <= pend_last_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ design/float_key_radix_sorter.sv @@
// float_key_radix_sorter: top level, configuration registers and the
// front / queue / back split. Depends on frk_pkg, frk_front, frk_queue, frk_back.
//
// Usage: stream in a set of vectors on in_*, one word per vector, with
// in_tlast on the final word. Up to MAX_ITEMS vectors are kept; further
// words of the same set are dropped, though their tlast still closes the set.
// The set comes back on out_* ordered by the raw bits of the configured
// component: negatives first in descending bit order (-0.0 last of them),
// then +0.0 and positives ascending. out_tlast marks the final vector.
// cfg_* writes sort_axis (index 0) and component_count (index 1); with three
// components w counts as zero and is sent as zero. cfg_ready is always high.
// Timing: loading takes one word per cycle while the queue holds words.
// After the closing word the back end runs a counting pass over the set,
// then 32 partition passes, then emits the vectors; each pass reads the
// set through the store's single read port. The front keeps accepting
// into a two-word queue while the back end is busy.
// Reset: sync, active low; empties the queue and the set, axis x, four
// components. A stalled receiver holds the output word and pauses emission.
module float_key_radix_sorter (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata, low bit up: comp_x, comp_y, comp_z, comp_w
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [frk_pkg::VEC_W-1:0]      in_tdata,
  input  logic                           in_tlast,     // final_item
  // out_tdata, low bit up: out_x, out_y, out_z, out_w
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [frk_pkg::VEC_W-1:0]      out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frk_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [frk_pkg::AXIS_W-1:0] sort_axis_r;
  logic [frk_pkg::CCNT_W-1:0] comp_cnt_r;

  frk_pkg::cfg_t     cfg;
  frk_pkg::q_entry_t push_entry, pop_entry;
  frk_pkg::q_stat_t  q_stat;
  logic              push, pop;

  assign cfg_ready = 1'b1;
  assign cfg.axis  = sort_axis_r;
  assign cfg.three = comp_cnt_r == frk_pkg::COMP_THREE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_axis_r <= '0;
      comp_cnt_r  <= frk_pkg::COMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frk_pkg::CFG_SORT_AXIS:  sort_axis_r <= cfg_data[frk_pkg::AXIS_W-1:0];
        frk_pkg::CFG_COMP_COUNT: comp_cnt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  frk_front u_front (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_stat, .push, .entry(push_entry)
  );

  frk_queue u_queue (
    .clk, .rst_n,
    .push, .wr_entry(push_entry),
    .pop, .rd_entry(pop_entry),
    .stat(q_stat)
  );

  frk_back u_back (
    .clk, .rst_n,
    .q_entry(pop_entry), .q_stat, .pop, .cfg,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

@@ design/frk_checker.sv @@
// frk_checker: port-level assertions for float_key_radix_sorter, bound to
// the top level below. Depends on frk_pkg.
module frk_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [frk_pkg::VEC_W-1:0]      out_tdata,
  input logic                           out_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // nothing left to send right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a new set needs a full sort, so the word after the last one is never ready
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output word right after end of set");

  // configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind float_key_radix_sorter frk_checker u_frk_checker (.*);

@@ bench/float_key_radix_sorter_tb.sv @@
`timescale 1ns / 1ps
// float_key_radix_sorter_tb: streams vector sets through the sorter under several axis
// and component-count settings and checks each sorted word against an in-bench model.
// Depends on frk_pkg and the float_key_radix_sorter RTL.
module float_key_radix_sorter_tb;

  localparam int WATCHDOG_LIMIT = 20000;  // must outlast the quiet stretch of a 64-vector sort
  localparam int SETTLE_CYCLES  = 80;
  localparam int RANDOM_ITEMS   = 140;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    frk_pkg::vec_t data;
    logic          last;
  } sorted_word_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  frk_pkg::vec_t                  in_tdata   = '0;   // low bit up: x, y, z, w
  logic                           in_tlast   = 1'b0; // final_item
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  frk_pkg::vec_t                  out_tdata;         // low bit up: x, y, z, w
  logic                           out_tlast;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [frk_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [frk_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  // model copy of the registers and the set being loaded
  logic [frk_pkg::AXIS_W-1:0] model_axis  = frk_pkg::AX_X;
  logic [frk_pkg::CCNT_W-1:0] model_count = frk_pkg::COMP_RESET;
  frk_pkg::vec_t              held_set_q[$];
  sorted_word_t               sorted_words_q[$];

  int mismatch_count     = 0;
  int idle_cycles        = 0;
  int stall_left         = 0;
  int random_items_sent  = 0;
  bit sender_idles       = 1'b1;
  bit receiver_stalls    = 1'b1;

  float_key_radix_sorter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic frk_pkg::vec_t make_vec(logic [frk_pkg::COMP_W-1:0] x,
                                             logic [frk_pkg::COMP_W-1:0] y,
                                             logic [frk_pkg::COMP_W-1:0] z,
                                             logic [frk_pkg::COMP_W-1:0] w);
    return {w, z, y, x};
  endfunction

  // raw key bits; with three components w reads as zero
  function automatic logic [frk_pkg::COMP_W-1:0] sort_key(frk_pkg::vec_t v,
                                                          logic [frk_pkg::AXIS_W-1:0] axis,
                                                          bit three);
    if (three && axis == frk_pkg::AX_W) return '0;
    return v[axis*frk_pkg::COMP_W +: frk_pkg::COMP_W];
  endfunction

  // Whole set: a stable ascending sort on the raw key, then the sign-set block
  // reversed and moved in front. Equal negative keys end up in reverse arrival
  // order, and -0.0 lands last among the negatives, right before +0.0.
  function automatic void predict_sorted_set();
    bit                         three;
    frk_pkg::vec_t              ordered[$];
    frk_pkg::vec_t              emitted[$];
    frk_pkg::vec_t              positives[$];
    logic [frk_pkg::COMP_W-1:0] k;
    int                         pos;
    sorted_word_t               w;
    three = (model_count == frk_pkg::COMP_THREE);
    foreach (held_set_q[i]) begin
      k   = sort_key(held_set_q[i], model_axis, three);
      pos = ordered.size();
      while (pos > 0 && sort_key(ordered[pos-1], model_axis, three) > k) pos--;
      ordered.insert(pos, held_set_q[i]);
    end
    foreach (ordered[i]) begin
      k = sort_key(ordered[i], model_axis, three);
      if (k[frk_pkg::COMP_W-1]) emitted.push_front(ordered[i]);
      else positives.push_back(ordered[i]);
    end
    foreach (positives[i]) emitted.push_back(positives[i]);
    foreach (emitted[i]) begin
      w.data = emitted[i];
      if (three) w.data[4*frk_pkg::COMP_W-1:3*frk_pkg::COMP_W] = '0;
      w.last = (i == emitted.size() - 1);
      sorted_words_q.push_back(w);
    end
    held_set_q.delete();
  endfunction

  // accepted input word: kept while the set has room; tlast closes the set
  // even when the word itself is dropped
  function automatic void record_word(frk_pkg::vec_t vec, logic last);
    if (held_set_q.size() < frk_pkg::MAX_ITEMS) held_set_q.push_back(vec);
    if (last) predict_sorted_set();
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_word(frk_pkg::vec_t data, logic last);
    sorted_word_t want;
    if (sorted_words_q.size() == 0) begin
      note_mismatch($sformatf("unexpected word %h last %b", data, last));
      return;
    end
    want = sorted_words_q.pop_front();
    for (int c = 0; c < 4; c++)
      if (data[c*frk_pkg::COMP_W +: frk_pkg::COMP_W] !==
          want.data[c*frk_pkg::COMP_W +: frk_pkg::COMP_W])
        note_mismatch($sformatf("component %0d: expected %h, got %h", c,
                                want.data[c*frk_pkg::COMP_W +: frk_pkg::COMP_W],
                                data[c*frk_pkg::COMP_W +: frk_pkg::COMP_W]));
    if (last !== want.last)
      note_mismatch($sformatf("out_tlast: expected %b, got %b (word %h)",
                              want.last, last, data));
  endfunction

  // biased toward signed zeros, extremes and near-equal keys so ties show up
  function automatic logic [frk_pkg::COMP_W-1:0] random_component();
    logic       sign;
    logic [1:0] low_bits;
    sign     = 1'($urandom_range(0, 1));
    low_bits = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4, 5:    return {sign, 29'h1FC0_0000, low_bits};
      default: return $urandom();
    endcase
  endfunction

  function automatic frk_pkg::vec_t random_vector();
    return make_vec(random_component(), random_component(),
                    random_component(), random_component());
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. send_word returns at the edge where its word was taken; valid is
  // only dropped when a gap is drawn, so back-to-back words keep it high.
  // ---------------------------------------------------------------------------
  task automatic send_word(frk_pkg::vec_t vec, logic last);
    int gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= vec;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    record_word(vec, last);
  endtask

  task automatic write_register(logic [frk_pkg::CFG_IDX_W-1:0] idx,
                                logic [frk_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == frk_pkg::CFG_SORT_AXIS) model_axis = value[frk_pkg::AXIS_W-1:0];
    else model_count = value;
    @(posedge clk);
  endtask

  // hold the sender until every pending word is out, then let the back end settle
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (sorted_words_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset settings (axis x, four components): signed zeros, extremes, equal
  // keys of both signs, then a one-word set
  task automatic test_directed_order();
    logic [frk_pkg::COMP_W-1:0] keys [8];
    keys = '{32'h3F80_0000, 32'h8000_0000, 32'h0000_0000, 32'hBF80_0000,
             32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hBF80_0000, 32'h3F80_0000};
    // y carries the arrival index so reordered ties are visible
    for (int i = 0; i < 8; i++)
      send_word(make_vec(keys[i], 32'(i), random_component(), random_component()), i == 7);
    send_word(random_vector(), 1'b1);
    wait_for_drain();
  endtask

  task automatic test_axis_settings();
    write_register(frk_pkg::CFG_SORT_AXIS, frk_pkg::CFG_DATA_W'(frk_pkg::AX_Y));
    send_word(make_vec(32'd1, 32'hC000_0000, 32'hFFFF_FFFF, 32'h0000_0000), 1'b0);
    send_word(make_vec(32'd2, 32'h4000_0000, 32'h0000_0000, 32'hFFFF_FFFF), 1'b0);
    send_word(make_vec(32'd3, 32'hC000_0000, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0);
    send_word(make_vec(32'd4, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1);
    wait_for_drain();
    // three components keyed on w: every key is zero, so arrival order holds
    // and w comes back as zero
    write_register(frk_pkg::CFG_COMP_COUNT, frk_pkg::COMP_THREE);
    write_register(frk_pkg::CFG_SORT_AXIS, frk_pkg::CFG_DATA_W'(frk_pkg::AX_W));
    for (int i = 0; i < 4; i++) send_word(random_vector(), i == 3);
    wait_for_drain();
    write_register(frk_pkg::CFG_SORT_AXIS, frk_pkg::CFG_DATA_W'(frk_pkg::AX_Z));
    for (int i = 0; i < 3; i++) send_word(random_vector(), i == 2);
    wait_for_drain();
    // any count other than three means four components
    write_register(frk_pkg::CFG_COMP_COUNT, 3'd7);
    write_register(frk_pkg::CFG_SORT_AXIS, frk_pkg::CFG_DATA_W'(frk_pkg::AX_W));
    for (int i = 0; i < 4; i++) send_word(random_vector(), i == 3);
    wait_for_drain();
  endtask

  // 70 words in one set: only the first MAX_ITEMS are kept, the dropped final
  // word still starts the sort; the next set must start from empty
  task automatic test_store_full();
    write_register(frk_pkg::CFG_SORT_AXIS, frk_pkg::CFG_DATA_W'(frk_pkg::AX_X));
    write_register(frk_pkg::CFG_COMP_COUNT, frk_pkg::COMP_RESET);
    for (int i = 0; i < frk_pkg::MAX_ITEMS + 6; i++)
      send_word(random_vector(), i == frk_pkg::MAX_ITEMS + 5);
    for (int i = 0; i < 3; i++) send_word(random_vector(), i == 2);
    wait_for_drain();
  endtask

  // phases of random settings; sets mostly small, a few large, sent back to
  // back inside a phase so the input queue fills while the back end sorts
  task automatic test_random_sets();
    logic [frk_pkg::CFG_DATA_W-1:0] axis_val;
    logic [frk_pkg::CFG_DATA_W-1:0] count_val;
    int                             n_sets;
    int                             set_len;
    while (random_items_sent < RANDOM_ITEMS) begin
      wait_for_drain();
      axis_val  = frk_pkg::CFG_DATA_W'($urandom_range(0, 3));
      count_val = ($urandom_range(0, 3) == 0)
                  ? frk_pkg::CFG_DATA_W'($urandom_range(0, 7))
                  : (($urandom_range(0, 1) != 0) ? frk_pkg::COMP_THREE
                                                 : frk_pkg::COMP_RESET);
      write_register(frk_pkg::CFG_SORT_AXIS, axis_val);
      write_register(frk_pkg::CFG_COMP_COUNT, count_val);
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      n_sets = $urandom_range(3, 6);
      for (int s = 0; s < n_sets; s++) begin
        set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, frk_pkg::MAX_ITEMS)
                                               : $urandom_range(1, 8);
        for (int i = 0; i < set_len; i++) send_word(random_vector(), i == set_len - 1);
        random_items_sent += set_len;
      end
    end
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: compare each taken word, then draw the stall before the next
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      check_word(out_tdata, out_tlast);
      stall_left = receiver_stalls ? $urandom_range(0, 4) : 0;
      out_tready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= (stall_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving on either stream
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("float_key_radix_sorter: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_order();
    test_axis_settings();
    test_store_full();
    test_random_sets();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("float_key_radix_sorter: match");
    end else begin
      $display("float_key_radix_sorter: mismatch");
    end
    $finish;
  end

endmodule
